/* design/cqo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cqo_pkg: shared widths and types for the circle quadrant outline block
// Field widths, the datapath widths of the square-and-add unit, and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package cqo_pkg;

	localparam int RadW  = 6;
	localparam int SqW   = 2 * RadW;
	localparam int DistW = SqW + 1;

	typedef logic [RadW-1:0]  rad_t;
	typedef logic [SqW-1:0]   sq_t;
	typedef logic [DistW-1:0] dist_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_R2   = 5'b00010,
		ST_XX   = 5'b00100,
		ST_YY   = 5'b01000,
		ST_SRCH = 5'b10000
	} state_t;

endpackage
`default_nettype wire

/* design/cqo_sqacc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cqo_sqacc: shared square-and-add unit
// Forms a*a + b. The sequencer uses it for R*R, x*x and x*x + y*y in turn.
// ----------------------------------------------------------------------------
module cqo_sqacc (
	input  wire cqo_pkg::rad_t  a,
	input  wire cqo_pkg::sq_t   b,
	output cqo_pkg::dist_t sum
);
	import cqo_pkg::*;

	sq_t prod;

	always_comb begin
		prod = a * a;
		sum  = DistW'(prod) + DistW'(b);
	end

endmodule
`default_nettype wire

/* design/circle_quadrant_outline.sv */
`timescale 1ns / 1ps
`default_nettype none
// The word for row 0 is registered in ST_R2, the state entered on the edge that takes start;
// each later row passes ST_XX, ST_YY and ST_SRCH, using the shared square-and-add unit
// (R*R, then x*x, then x*x + y*y) and a search that steps the half-width up by one.
// Results appear for one cycle on valid, no stall.
// arst_n clears the sequencer and the result strobe; payload registers are not reset.
// ----------------------------------------------------------------------------
// circle_quadrant_outline: quarter-circle half-widths without square roots
// Takes a radius and emits one word per row 0..R, each carrying the outline
// half-width found by an incremental distance search.
// ----------------------------------------------------------------------------
module circle_quadrant_outline (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  start,
	input  wire  cqo_pkg::rad_t radius,
	output logic busy,
	output logic valid,
	output cqo_pkg::rad_t row,
	output cqo_pkg::rad_t half_width,
	output logic last
);
	import cqo_pkg::*;

	state_t state_q;
	rad_t   r_q;
	rad_t   row_q;
	rad_t   y_q;
	sq_t    r2_q;
	sq_t    acc_q;
	dist_t  d_q;
	sq_t    gap_q;
	logic   stepped_q;

	rad_t   sq_a;
	sq_t    sq_b;
	dist_t  sq_sum;
	logic   reached;
	logic   take_upper;
	rad_t   hw_sel;
	dist_t  over;

	cqo_sqacc u_sqacc (
		.a   (sq_a),
		.b   (sq_b),
		.sum (sq_sum)
	);

	always_comb begin
		sq_a = y_q;
		sq_b = '0;
		case (state_q)
			ST_R2:   sq_a = r_q;
			ST_XX:   sq_a = r_q - row_q;
			ST_YY:   begin
				sq_a = y_q;
				sq_b = acc_q;
			end
			default: sq_a = y_q;
		endcase
	end

	// After a step, y_q already holds the upper candidate; pick it when the
	// overshoot is no larger than the gap left before the step.
	always_comb begin
		reached    = d_q >= DistW'(r2_q);
		over       = d_q - DistW'(r2_q);
		take_upper = over <= DistW'(gap_q);
		if (stepped_q && !take_upper)
			hw_sel = y_q - RadW'(1);
		else
			hw_sel = y_q;
	end

	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid   <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_R2;
				end
				ST_R2: begin
					valid <= 1'b1;
					if (r_q == '0)
						state_q <= ST_IDLE;
					else
						state_q <= ST_XX;
				end
				ST_XX:   state_q <= ST_YY;
				ST_YY:   state_q <= ST_SRCH;
				ST_SRCH: begin
					if (reached) begin
						valid <= 1'b1;
						if (row_q == r_q)
							state_q <= ST_IDLE;
						else
							state_q <= ST_XX;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					r_q   <= radius;
					row_q <= '0;
					y_q   <= '0;
				end
			end
			ST_R2: begin
				r2_q       <= sq_sum[SqW-1:0];
				row        <= '0;
				half_width <= '0;
				last       <= r_q == '0;
				row_q      <= RadW'(1);
			end
			ST_XX: acc_q <= sq_sum[SqW-1:0];
			ST_YY: begin
				d_q       <= sq_sum;
				stepped_q <= 1'b0;
			end
			ST_SRCH: begin
				if (reached) begin
					row        <= row_q;
					half_width <= hw_sel;
					last       <= row_q == r_q;
					y_q        <= hw_sel;
					row_q      <= row_q + RadW'(1);
				end else begin
					gap_q     <= sq_t'(DistW'(r2_q) - d_q);
					d_q       <= d_q + DistW'({y_q, 1'b1});
					y_q       <= y_q + RadW'(1);
					stepped_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Between two words the sequencer passes through another state, so two words never come back to back.
	assert property (@(posedge clk) disable iff (!arst_n) valid |=> !valid)
		else $error("result words issued on consecutive cycles");

	// A word that is not the last one leaves the block still working.
	assert property (@(posedge clk) disable iff (!arst_n) (valid && !last) |-> busy)
		else $error("block went idle before the last row");

	assert property (@(posedge clk) disable iff (!arst_n) (valid && last) |-> row == r_q)
		else $error("last flag on a row other than the radius");

	assert property (@(posedge clk) disable iff (!arst_n) valid |-> half_width <= r_q)
		else $error("half-width exceeds the radius");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for circle_quadrant_outline
// Sends radii through the start/busy handshake in random bursts and computes
// each outline row in a local model. Every word on the result strobe is
// checked against the oldest word still due.
// ----------------------------------------------------------------------------
module tb;
	import cqo_pkg::*;

	typedef struct {
		rad_t row;
		rad_t half_width;
		logic last;
	} outline_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	rad_t radius = '0;
	logic busy;
	logic valid;
	rad_t row;
	rad_t half_width;
	logic last;

	rad_t radii_to_send[$];
	outline_word_t outline_due[$];
	outline_word_t due_word;

	// Local copy of the sequencer state, advanced by the row tracer.
	rad_t pred_radius;
	rad_t pred_row;
	rad_t pred_y;
	dist_t pred_dist;
	sq_t pred_gap;

	int items_total;
	int items_taken = 0;
	int words_checked = 0;
	int mismatches = 0;
	int largest_radius = 0;
	int gap_left = 0;
	int burst_left = 1;

	circle_quadrant_outline dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.radius(radius),
		.busy(busy),
		.valid(valid),
		.row(row),
		.half_width(half_width),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Walk the rows of one radius and queue the words the block should emit.
	function automatic void trace_quadrant(input rad_t r);
		sq_t r_sq;
		outline_word_t w;
		int i, x, y, steps, hw;
		pred_radius = r;
		r_sq = r * r;
		pred_row = '0;
		pred_y = '0;
		pred_dist = r_sq;
		pred_gap = '0;
		w.row = '0;
		w.half_width = '0;
		w.last = (r == 0);
		outline_due.push_back(w);
		for (i = 1; i <= r; i++) begin
			x = r - i;
			y = pred_y;
			hw = y;
			steps = 0;
			pred_row = i;
			pred_dist = x * x + y * y;
			if (pred_dist < r_sq) begin
				while (steps <= r) begin
					pred_gap = r_sq - pred_dist;
					pred_dist = pred_dist + 2 * y + 1;
					if (pred_dist >= r_sq) begin
						// Round to whichever side has the smaller squared-distance error, the upper one on a tie.
						hw = (pred_dist - r_sq <= pred_gap) ? y + 1 : y;
						break;
					end
					y++;
					steps++;
					hw = y;
				end
			end
			if (hw > r)
				hw = r;
			pred_y = hw;
			w.row = pred_row;
			w.half_width = pred_y;
			w.last = (i == r);
			outline_due.push_back(w);
		end
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	// Driver: a word is taken when start is high and busy is low at the edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				trace_quadrant(radius);
				items_taken++;
				if (radius > largest_radius)
					largest_radius = radius;
			end
			// A word still waiting on busy is held as it is.
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					start <= 1'b0;
					gap_left--;
				end else if (radii_to_send.size() > 0) begin
					start <= 1'b1;
					radius <= radii_to_send.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: results cannot be held off, so every strobe is checked at once.
	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (outline_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected word row=%0d half_width=%0d last=%0b",
					row, half_width, last));
			end else begin
				due_word = outline_due.pop_front();
				words_checked++;
				if (row !== due_word.row || half_width !== due_word.half_width ||
						last !== due_word.last)
					flag_mismatch($sformatf(
						"expected row=%0d half_width=%0d last=%0b, got row=%0d half_width=%0d last=%0b",
						due_word.row, due_word.half_width, due_word.last,
						row, half_width, last));
			end
		end
	end

	initial begin
		int k, pick;
		// Directed part: both ends of the range and a spread of sizes in between.
		radii_to_send = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd7, 6'd10, 6'd16,
			6'd21, 6'd31, 6'd32, 6'd42, 6'd62, 6'd63, 6'd0, 6'd63, 6'd1};
		for (k = 0; k < 400; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)
				radii_to_send.push_back(rad_t'($urandom_range(0, 7)));
			else if (pick < 40)
				radii_to_send.push_back(rad_t'($urandom_range(56, 63)));
			else
				radii_to_send.push_back(rad_t'($urandom_range(0, 63)));
		end
		items_total = radii_to_send.size();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (items_taken < items_total)
			@(posedge clk);
		while (outline_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d radii (largest %0d) in random bursts; checked %0d outline words.",
			items_taken, largest_radius, words_checked);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d words still due.", outline_due.size());
		$display("status: fail");
		$finish;
	end

endmodule
